// File: src/vps_pkg.sv
package vps_pkg;
   localparam int COORD_WIDTH_DEF = 32;
   localparam logic [16:0] DRAG_RESET = 17'd65470;
   localparam logic [2:0] KIND_STEP = 3'd0;
   localparam logic [2:0] KIND_ATTRACT = 3'd1;
   localparam logic [2:0] KIND_REPEL = 3'd2;
   localparam logic [2:0] KIND_BOX = 3'd3;
   localparam logic [2:0] KIND_LOAD = 3'd4;
   localparam logic [2:0] CSR_DRAG = 3'd0;
   localparam logic [2:0] CSR_LOCKED = 3'd1;
   localparam logic [2:0] CSR_FORCE_X = 3'd2;
   localparam logic [2:0] CSR_FORCE_Y = 3'd3;
   localparam logic [2:0] CSR_FORCE_Z = 3'd4;

   typedef struct packed {
      logic [2:0] kind;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
      logic signed [31:0] bx;
      logic signed [31:0] by_max;
      logic signed [31:0] bz;
      logic [30:0] radius;
      logic signed [31:0] strength;
      logic [30:0] step_time;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture request, start op
      logic step;     // advance one micro-step
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic done;
   } sts_type;
endpackage

// File: src/vps_if.sv
interface vps_req_if;
   import vps_pkg::*;
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface vps_rsp_if;
   import vps_pkg::*;
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: src/verlet_particle_step.sv
// One Verlet particle in signed Q16.16. Each request beat carries a kind (step,
// attract, repel, box, load) and returns one response beat with the position.
// Items run one at a time; a new request is accepted only after the response
// beat of the last one is taken. A step runs three multiply/update pairs; box,
// load, unused kinds and any locked item finish in the dispatch phase; attract/
// repel inside the radius run the 16-step weight divider, 32-step square root
// and a 48-step divide per axis in the datapath, and stop at the distance test
// when it rejects them. Response backpressure stalls the block. Configuration
// writes are to be made only while idle; the block itself does not enforce this.
module verlet_particle_step #(
   parameter int COORD_WIDTH = vps_pkg::COORD_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   vps_req_if.sink req,
   vps_rsp_if.source rsp,
   input  logic csr_write,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_data
);
   import vps_pkg::*;
   cmd_type cmd;
   sts_type sts;

   vps_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd(cmd), .sts(sts)
   );

   vps_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req(req.data), .rsp(rsp.data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );
endmodule

// File: src/vps_ctrl.sv
module vps_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   output vps_pkg::cmd_type cmd,
   input  vps_pkg::sts_type sts
);
   import vps_pkg::*;
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_BUSY = 2'd1;
   localparam logic [1:0] ST_OUT = 2'd2;
   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            cmd.step = 1'b1;
            if (sts.done) state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BUSY |-> !req_ready) else $error("accept while busy");
   a_load_to_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_BUSY) else $error("load lost");
endmodule

// File: src/vps_datapath.sv
module vps_datapath #(
   parameter int COORD_WIDTH = vps_pkg::COORD_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  vps_pkg::cmd_type cmd,
   output vps_pkg::sts_type sts,
   input  vps_pkg::req_type req,
   output vps_pkg::rsp_type rsp,
   input  logic csr_write,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_data
);
   import vps_pkg::*;
   localparam int SB = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
   localparam logic signed [65:0] SMAX = 66'sd1 <<< (SB - 1);
   localparam logic signed [65:0] SATMAX = SMAX - 66'sd1;
   localparam logic signed [65:0] SATMIN = -SMAX;

   // sequence phases
   localparam logic [3:0] PH_DIFF = 4'd0;   // deltas, dispatch
   localparam logic [3:0] PH_SQ = 4'd1;     // squares, one axis a cycle
   localparam logic [3:0] PH_CHK = 4'd2;
   localparam logic [3:0] PH_K = 4'd3;      // 16 restoring steps
   localparam logic [3:0] PH_SQRT = 4'd4;   // 32 root steps
   localparam logic [3:0] PH_S = 4'd5;
   localparam logic [3:0] PH_DIV = 4'd6;    // per axis 48-bit divide
   localparam logic [3:0] PH_MUL = 4'd7;
   localparam logic [3:0] PH_FIN = 4'd8;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > SATMAX) return SATMAX[31:0];
      if (v < SATMIN) return SATMIN[31:0];
      return v[31:0];
   endfunction

   function automatic logic signed [65:0] fl16(input logic signed [65:0] v);
      return v >>> 16;
   endfunction

   logic [16:0] drag_ff;
   logic locked_ff;
   logic signed [31:0] force_ff [3];
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] prev_ff [3];
   logic signed [31:0] vel_ff [3];
   req_type req_ff;
   logic [3:0] ph_ff;
   logic [5:0] cnt_ff;
   logic [1:0] ax_ff;
   logic done_ff;
   logic signed [32:0] d_ff [3];
   logic far_ff;
   logic [63:0] d2_ff, r2_ff, rem_ff;
   logic [15:0] k_ff;
   logic [63:0] sx_ff, sr_ff;
   logic [63:0] bit_ff;
   logic signed [31:0] s_ff;
   logic [47:0] nq_ff;
   logic [31:0] drem_ff;
   logic neg_ff;
   logic signed [65:0] p_ff;

   logic signed [31:0] dcur;
   logic [63:0] rs, rnext;
   logic [32:0] dtrial;
   logic signed [65:0] sum;
   logic signed [65:0] nw;

   assign sts.done = done_ff;
   assign rsp.pos_x = pos_ff[0];
   assign rsp.pos_y = pos_ff[1];
   assign rsp.pos_z = pos_ff[2];

   always_comb begin
      dcur = d_ff[ax_ff][31:0];
      rs = rem_ff << 1;
      rnext = sr_ff + bit_ff;
      dtrial = {drem_ff, nq_ff[47]} - {1'b0, sr_ff[31:0]};
      sum = 66'(signed'(pos_ff[ax_ff])) + p_ff;
      nw = 66'(signed'(pos_ff[ax_ff])) - p_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drag_ff <= DRAG_RESET;
         locked_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            force_ff[i] <= '0; pos_ff[i] <= '0; prev_ff[i] <= '0; vel_ff[i] <= '0;
         end
         done_ff <= 1'b0;
         ph_ff <= PH_DIFF;
      end else begin
         done_ff <= 1'b0;
         if (csr_write) begin
            case (csr_index)
               CSR_DRAG: drag_ff <= csr_data[16:0];
               CSR_LOCKED: locked_ff <= csr_data[0];
               CSR_FORCE_X: force_ff[0] <= csr_data;
               CSR_FORCE_Y: force_ff[1] <= csr_data;
               CSR_FORCE_Z: force_ff[2] <= csr_data;
               default: ;
            endcase
         end
         if (cmd.load) begin
            req_ff <= req;
            ph_ff <= PH_DIFF;
            ax_ff <= 2'd0;
         end else if (cmd.step && !done_ff) begin
            case (ph_ff)
               PH_DIFF: begin
                  for (int i = 0; i < 3; i++) begin
                     d_ff[i] <= 33'(signed'(i == 0 ? req_ff.ax : i == 1 ? req_ff.ay
                        : req_ff.az)) - 33'(signed'(pos_ff[i]));
                  end
                  far_ff <= 1'b0;
                  d2_ff <= '0;
                  ax_ff <= 2'd0;
                  if (locked_ff) done_ff <= 1'b1;
                  else case (req_ff.kind)
                     KIND_ATTRACT, KIND_REPEL: ph_ff <= PH_SQ;
                     KIND_STEP: begin
                        ph_ff <= PH_MUL;
                        p_ff <= 66'(signed'(pos_ff[0])) - 66'(signed'(prev_ff[0]));
                     end
                     KIND_BOX: begin
                        for (int i = 0; i < 3; i++) begin
                           logic signed [31:0] lo, hi;
                           lo = i == 0 ? req_ff.ax : i == 1 ? req_ff.ay : req_ff.az;
                           hi = i == 0 ? req_ff.bx : i == 1 ? req_ff.by_max : req_ff.bz;
                           if (pos_ff[i] > hi) begin
                              pos_ff[i] <= sat32(66'(hi));
                              prev_ff[i] <= sat32(66'(sat32(66'(hi))) + 66'(vel_ff[i]));
                           end else if (pos_ff[i] < lo) begin
                              pos_ff[i] <= sat32(66'(lo));
                              prev_ff[i] <= sat32(66'(sat32(66'(lo))) + 66'(vel_ff[i]));
                           end
                        end
                        done_ff <= 1'b1;
                     end
                     KIND_LOAD: begin
                        pos_ff[0] <= sat32(66'(req_ff.ax));
                        pos_ff[1] <= sat32(66'(req_ff.ay));
                        pos_ff[2] <= sat32(66'(req_ff.az));
                        prev_ff[0] <= sat32(66'(req_ff.ax));
                        prev_ff[1] <= sat32(66'(req_ff.ay));
                        prev_ff[2] <= sat32(66'(req_ff.az));
                        for (int i = 0; i < 3; i++) vel_ff[i] <= '0;
                        done_ff <= 1'b1;
                     end
                     default: done_ff <= 1'b1;
                  endcase
               end
               PH_SQ: begin
                  if (d_ff[ax_ff] >= 33'sh080000000 || d_ff[ax_ff] <= -33'sh080000000)
                     far_ff <= 1'b1;
                  d2_ff <= d2_ff + 64'(dcur * dcur);
                  if (ax_ff == 2'd2) begin
                     ph_ff <= PH_CHK;
                     r2_ff <= 64'(req_ff.radius) * 64'(req_ff.radius);
                  end else ax_ff <= ax_ff + 2'd1;
               end
               PH_CHK: begin
                  if (far_ff || !(d2_ff < r2_ff) || d2_ff == '0) done_ff <= 1'b1;
                  else begin
                     rem_ff <= r2_ff - d2_ff;
                     k_ff <= '0;
                     cnt_ff <= 6'd0;
                     ph_ff <= PH_K;
                  end
               end
               PH_K: begin
                  if (rs >= r2_ff) begin
                     rem_ff <= rs - r2_ff; k_ff <= {k_ff[14:0], 1'b1};
                  end else begin
                     rem_ff <= rs; k_ff <= {k_ff[14:0], 1'b0};
                  end
                  if (cnt_ff == 6'd15) begin
                     ph_ff <= PH_SQRT;
                     cnt_ff <= 6'd0;
                     sx_ff <= d2_ff;
                     sr_ff <= '0;
                     bit_ff <= 64'd1 << 62;
                  end else cnt_ff <= cnt_ff + 6'd1;
               end
               PH_SQRT: begin
                  // fixed 32 steps; leading steps with bit > x are no-ops
                  if (sx_ff >= rnext) begin
                     sx_ff <= sx_ff - rnext;
                     sr_ff <= (sr_ff >> 1) + bit_ff;
                  end else sr_ff <= sr_ff >> 1;
                  bit_ff <= bit_ff >> 2;
                  if (cnt_ff == 6'd31) ph_ff <= PH_S;
                  else cnt_ff <= cnt_ff + 6'd1;
               end
               PH_S: begin
                  s_ff <= sat32(fl16(66'(req_ff.strength) * 66'(signed'({1'b0,
                     req_ff.step_time}))));
                  ax_ff <= 2'd0;
                  ph_ff <= PH_DIV;
                  cnt_ff <= 6'd0;
                  neg_ff <= d_ff[0][32];
                  nq_ff <= 48'(d_ff[0][32] ? -d_ff[0] : d_ff[0]) * 48'(k_ff);
                  drem_ff <= '0;
               end
               PH_DIV: begin
                  // unsigned restoring divide of |d|*k by mag, one bit a cycle
                  if (!dtrial[32]) begin
                     drem_ff <= dtrial[31:0];
                     nq_ff <= {nq_ff[46:0], 1'b1};
                  end else begin
                     drem_ff <= {drem_ff[30:0], nq_ff[47]};
                     nq_ff <= {nq_ff[46:0], 1'b0};
                  end
                  if (cnt_ff == 6'd47) ph_ff <= PH_MUL;
                  else cnt_ff <= cnt_ff + 6'd1;
               end
               PH_MUL: begin
                  if (req_ff.kind == KIND_STEP) begin
                     p_ff <= fl16(p_ff * 66'(signed'({1'b0, drag_ff})));
                  end else begin
                     logic signed [49:0] u;
                     u = neg_ff ? -50'(signed'({1'b0, nq_ff})) : 50'(signed'({1'b0, nq_ff}));
                     p_ff <= fl16(66'(u) * 66'(s_ff));
                  end
                  ph_ff <= PH_FIN;
               end
               PH_FIN: begin
                  if (req_ff.kind == KIND_STEP) begin
                     logic signed [31:0] v;
                     v = sat32(p_ff);
                     vel_ff[ax_ff] <= v;
                     prev_ff[ax_ff] <= pos_ff[ax_ff];
                     pos_ff[ax_ff] <= sat32(66'(signed'(pos_ff[ax_ff])) + 66'(v)
                        + 66'(signed'(force_ff[ax_ff])));
                  end else if (req_ff.kind == KIND_REPEL) pos_ff[ax_ff] <= sat32(nw);
                  else pos_ff[ax_ff] <= sat32(sum);
                  if (ax_ff == 2'd2) done_ff <= 1'b1;
                  else begin
                     ax_ff <= ax_ff + 2'd1;
                     if (req_ff.kind == KIND_STEP) begin
                        ph_ff <= PH_MUL;
                        p_ff <= 66'(signed'(pos_ff[ax_ff + 2'd1]))
                           - 66'(signed'(prev_ff[ax_ff + 2'd1]));
                     end else begin
                        ph_ff <= PH_DIV;
                        cnt_ff <= 6'd0;
                        drem_ff <= '0;
                        neg_ff <= d_ff[ax_ff + 2'd1][32];
                        nq_ff <= 48'(d_ff[ax_ff + 2'd1][32] ? -d_ff[ax_ff + 2'd1]
                           : d_ff[ax_ff + 2'd1]) * 48'(k_ff);
                     end
                  end
               end
               default: done_ff <= 1'b1;
            endcase
         end
      end
   end

   a_k_len: assert property (@(posedge clock) disable iff (reset)
      ph_ff == PH_K |-> cnt_ff <= 6'd15) else $error("k overrun");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      ph_ff == PH_DIV |-> cnt_ff <= 6'd47) else $error("divide overrun");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done not a pulse");
endmodule

// File: dv/verlet_particle_step_test.sv
module verlet_particle_step_test;
   import vps_pkg::*;

   localparam int CYCLE_LIMIT = 900000;
   localparam longint SMAX = 64'sd2147483647;
   localparam longint SMIN = -64'sd2147483648;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   vps_req_if req_ch ();
   vps_rsp_if rsp_ch ();

   verlet_particle_step u_dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // particle shadow state and register copy
   longint pos_m [3];
   longint prev_m [3];
   longint vel_m [3];
   longint force_m [3];
   longint unsigned drag_m;
   bit locked_m;

   req_type pending_q [$];
   rsp_type expected_pos_q [$];
   int mismatches = 0;
   int cycle_count = 0;
   int beats_out = 0;
   int beats_back = 0;
   bit quiet = 1'b0;        // no idling in the final stretch
   bit hold_off = 1'b0;
   bit req_taken = 1'b0;    // request beat accepted at the last rising edge

   function automatic longint clamp32(longint v);
      if (v > SMAX) return SMAX;
      if (v < SMIN) return SMIN;
      return v;
   endfunction

   // floor division by 2^16
   function automatic longint fshr16(longint x);
      return x >>> 16;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic void apply_influence(req_type it, bit repel);
      longint d [3];
      longint src [3];
      longint unsigned d2, r, r2, rem, k, mag;
      longint s, u, f;
      src[0] = it.ax; src[1] = it.ay; src[2] = it.az;
      d2 = 0;
      for (int i = 0; i < 3; i++) begin
         d[i] = src[i] - pos_m[i];
         if (d[i] >= 64'sh80000000 || d[i] <= -64'sh80000000) return;
         d2 += longint'(d[i] * d[i]);
      end
      r = it.radius;
      r2 = r * r;
      if (!(d2 < r2) || d2 == 0) return;
      rem = r2 - d2;
      k = 0;
      // restoring divide for the Q0.16 weight; rem < r2 < 2^62 so no overflow
      for (int i = 0; i < 16; i++) begin
         rem <<= 1;
         k <<= 1;
         if (rem >= r2) begin
            rem -= r2;
            k |= 1;
         end
      end
      mag = int_sqrt(d2);
      if (mag == 0) return;
      s = clamp32(fshr16(longint'(it.strength) * longint'({33'd0, it.step_time})));
      for (int i = 0; i < 3; i++) begin
         u = (d[i] * longint'(k)) / longint'(mag);
         f = fshr16(u * s);
         pos_m[i] = clamp32(repel ? pos_m[i] - f : pos_m[i] + f);
      end
   endfunction

   function automatic rsp_type position_after(req_type it);
      rsp_type o;
      longint lo [3];
      longint hi [3];
      longint v;
      lo[0] = it.ax; lo[1] = it.ay; lo[2] = it.az;
      hi[0] = it.bx; hi[1] = it.by_max; hi[2] = it.bz;
      if (!locked_m) begin
         case (it.kind)
            KIND_STEP: begin
               for (int i = 0; i < 3; i++) begin
                  v = clamp32(fshr16((pos_m[i] - prev_m[i]) * longint'(drag_m)));
                  vel_m[i] = v;
                  prev_m[i] = pos_m[i];
                  pos_m[i] = clamp32(pos_m[i] + v + force_m[i]);
               end
            end
            KIND_ATTRACT: apply_influence(it, 1'b0);
            KIND_REPEL: apply_influence(it, 1'b1);
            KIND_BOX: begin
               // max test first; an inverted box lands on max or min
               for (int i = 0; i < 3; i++) begin
                  if (pos_m[i] > hi[i]) begin
                     pos_m[i] = hi[i];
                     prev_m[i] = clamp32(pos_m[i] + vel_m[i]);
                  end else if (pos_m[i] < lo[i]) begin
                     pos_m[i] = lo[i];
                     prev_m[i] = clamp32(pos_m[i] + vel_m[i]);
                  end
               end
            end
            KIND_LOAD: begin
               for (int i = 0; i < 3; i++) begin
                  pos_m[i] = lo[i];
                  prev_m[i] = lo[i];
                  vel_m[i] = 0;
               end
            end
            default: ;  // unused kinds leave the particle alone
         endcase
      end
      o.pos_x = pos_m[0][31:0];
      o.pos_y = pos_m[1][31:0];
      o.pos_z = pos_m[2][31:0];
      return o;
   endfunction

   // Driver: one beat per handshake, random idle bursts between beats.
   int src_gap = 0;
   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_ch.valid && !req_taken) begin
            // holding current beat
         end else if (src_gap > 0) begin
            src_gap--;
            req_ch.valid <= 1'b0;
         end else if (!hold_off && pending_q.size() > 0) begin
            req_ch.valid <= 1'b1;
            req_ch.data <= pending_q.pop_front();
            if (!quiet && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 12);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Sink backpressure, also in bursts.
   int sink_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (sink_gap > 0) begin
            sink_gap--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 6) == 0) sink_gap = $urandom_range(1, 12);
         end
      end
   end

   // Monitor: predict on each accepted request beat, compare each response
   // beat with the oldest expected position.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready) begin
         expected_pos_q = {expected_pos_q, position_after(req_ch.data)};
         beats_out++;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         beats_back++;
         if (expected_pos_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response beat %h", rsp_ch.data);
         end else begin
            rsp_type e;
            e = expected_pos_q.pop_front();
            if (rsp_ch.data.pos_x !== e.pos_x || rsp_ch.data.pos_y !== e.pos_y ||
                rsp_ch.data.pos_z !== e.pos_z) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("position mismatch exp %h %h %h got %h %h %h",
                           e.pos_x, e.pos_y, e.pos_z, rsp_ch.data.pos_x,
                           rsp_ch.data.pos_y, rsp_ch.data.pos_z);
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom_range(0, 20) << 16;
         3: return -($urandom_range(0, 20) << 16);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type make_item(logic [2:0] kind);
      req_type it;
      it.kind = kind;
      it.ax = rand_coord(); it.ay = rand_coord(); it.az = rand_coord();
      it.bx = rand_coord(); it.by_max = rand_coord(); it.bz = rand_coord();
      it.radius = 31'($urandom);
      it.strength = $urandom;
      it.step_time = 31'($urandom);
      return it;
   endfunction

   // source near the particle so the influence test can pass; items are
   // queued ahead of prediction, so a zone around the origin is used
   function automatic req_type near_source(logic [2:0] kind);
      req_type it;
      it = make_item(kind);
      it.ax = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
      it.ay = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
      it.az = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
      it.radius = 31'($urandom_range(1 << 16, 16 << 16));
      it.strength = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      it.step_time = 31'($urandom_range(0, 1 << 17));
      return it;
   endfunction

   function automatic void queue_item(req_type it);
      pending_q = {pending_q, it};
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      // shadow update, registers only change between phases
      case (idx)
         CSR_DRAG: drag_m = 64'(val[16:0]);
         CSR_LOCKED: locked_m = val[0];
         CSR_FORCE_X: force_m[0] = longint'($signed(val));
         CSR_FORCE_Y: force_m[1] = longint'($signed(val));
         CSR_FORCE_Z: force_m[2] = longint'($signed(val));
         default: ;
      endcase
   endtask

   // wait until every queued beat is out and answered, then settle
   task automatic drain();
      while (pending_q.size() > 0 || req_ch.valid || expected_pos_q.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic run_phase(int count, int mix);
      req_type it;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: it = make_item(KIND_STEP);
            3: it = near_source(KIND_ATTRACT);
            4: it = near_source(KIND_REPEL);
            5: it = make_item($urandom_range(0, 1) ? KIND_ATTRACT : KIND_REPEL);
            6: begin
               it = make_item(KIND_BOX);
               it.ax = -($urandom_range(0, 6) << 16); it.ay = -($urandom_range(0, 6) << 16);
               it.az = -($urandom_range(0, 6) << 16);
               it.bx = $urandom_range(0, 6) << 16; it.by_max = $urandom_range(0, 6) << 16;
               it.bz = $urandom_range(0, 6) << 16;
            end
            7: it = make_item(mix ? KIND_BOX : KIND_LOAD);
            8: begin
               it = make_item(KIND_LOAD);
               it.ax = $signed($urandom_range(0, 20 << 16)) - (10 << 16);
               it.ay = $signed($urandom_range(0, 20 << 16)) - (10 << 16);
               it.az = $signed($urandom_range(0, 20 << 16)) - (10 << 16);
            end
            default: it = make_item(3'($urandom_range(5, 7)));
         endcase
         queue_item(it);
      end
   endtask

   initial begin
      req_type it;
      drag_m = 64'(DRAG_RESET);
      locked_m = 1'b0;
      for (int i = 0; i < 3; i++) begin
         pos_m[i] = 0; prev_m[i] = 0; vel_m[i] = 0; force_m[i] = 0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: load, steps, influences, boxes, extremes, unused kinds
      write_reg(CSR_FORCE_X, 32'h0000_8000);
      write_reg(CSR_FORCE_Y, 32'hFFFF_0000);
      write_reg(CSR_FORCE_Z, 32'h7FFF_FFFF);
      write_reg(3'd7, 32'hFFFF_FFFF);   // out-of-range index, ignored
      it = make_item(KIND_LOAD);
      it.ax = 32'h0001_0000; it.ay = 32'h8000_0000; it.az = 32'h7FFF_FFFF;
      queue_item(it);
      repeat (3) queue_item(make_item(KIND_STEP));
      it = make_item(KIND_LOAD); it.ax = 0; it.ay = 0; it.az = 0;
      queue_item(it);
      it = make_item(KIND_ATTRACT); it.ax = 0; it.ay = 0; it.az = 0;  // zero distance
      it.radius = 31'h7FFFFFFF;
      queue_item(it);
      it.ax = 32'h0002_0000; it.radius = '0;                          // zero radius
      queue_item(it);
      it.radius = 31'h0004_0000; it.strength = 32'h7FFFFFFF; it.step_time = 31'h7FFFFFFF;
      queue_item(it);
      it.kind = KIND_REPEL; it.strength = 32'h80000000;
      queue_item(it);
      it.ax = 32'h8000_0000; it.radius = 31'h7FFFFFFF;                // far source
      queue_item(it);
      it = make_item(KIND_BOX);                                       // inverted box
      it.ax = 32'h0005_0000; it.bx = 32'hFFFB_0000;
      it.ay = 32'h8000_0000; it.by_max = 32'h7FFF_FFFF;
      it.az = 32'h7FFF_FFFF; it.bz = 32'h8000_0000;
      queue_item(it);
      for (int k = 5; k < 8; k++) queue_item(make_item(k[2:0]));
      drain();

      write_reg(CSR_DRAG, 32'd65536);
      write_reg(CSR_LOCKED, 32'd1);
      repeat (4) queue_item(make_item(3'($urandom_range(0, 4))));
      drain();
      write_reg(CSR_LOCKED, 32'd0);
      write_reg(CSR_DRAG, 32'h1FFFF);    // above unity, amplifies
      queue_item(make_item(KIND_STEP));
      queue_item(make_item(KIND_STEP));
      drain();

      // random phases with assorted settings
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: write_reg(CSR_DRAG, 32'd0);
            1: write_reg(CSR_DRAG, 32'(DRAG_RESET));
            2: write_reg(CSR_DRAG, $urandom_range(0, 65536));
            default: write_reg(CSR_DRAG, $urandom_range(60000, 65536));
         endcase
         write_reg(CSR_FORCE_X, $signed($urandom_range(0, 1 << 16)) - (1 << 15));
         write_reg(CSR_FORCE_Y, ph == 1 ? 32'h80000000 : $urandom_range(0, 1 << 12));
         write_reg(CSR_FORCE_Z, $urandom);
         write_reg(CSR_LOCKED, 32'(ph == 3));
         if (ph == 4) quiet = 1'b1;
         run_phase(45, ph % 2);
         // sender holds off until the block is fully drained
         while (pending_q.size() > 20) @(posedge clock);
         hold_off = 1'b1;
         while (req_ch.valid || expected_pos_q.size() > 0) @(posedge clock);
         hold_off = 1'b0;
         run_phase(45, 1);
         drain();
      end

      $display("Sent %0d beats, %0d responses back, over all item kinds", beats_out,
               beats_back);
      $display("Drag, lock and force settings swept incl. extremes");
      if (mismatches == 0 && expected_pos_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
